@@ hdl/rsmst_pkg.sv @@
// shared types and constants for the range sum / max segment tree
`default_nettype none

package rsmst_pkg;

    localparam int MAX_ENTRIES_DEF = 32768;
    localparam int SUM_W           = 32;
    localparam int VAL_W           = 16;
    localparam logic [15:0] COUNT_RESET = 16'd32768;

    typedef enum logic [1:0] {
        CMD_UPDATE = 2'd0,
        CMD_MAX    = 2'd1,
        CMD_SUM    = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UPD_DOWN,
        ST_UP_READ,
        ST_UP_WRITE,
        ST_Q_SPLIT,
        ST_Q_LEFT,
        ST_Q_RIGHT,
        ST_Q_DRAIN
    } state_t;

endpackage

`default_nettype wire

@@ hdl/rsmst_ram.sv @@
// generic single write port, single registered read port memory
`default_nettype none

module rsmst_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 65536
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ hdl/range_sum_max_segment_tree.sv @@
// top level: segment tree with point update, range maximum and range sum
//
// input transactions on s_*: s_tuser carries the command (update, range max,
// range sum), s_tdata the first index, last index and new value.
// results leave on m_*: m_tdata is the 32-bit answer, m_tuser the error flag.
// updates and unused commands give no result transaction.
// cfg_* writes element_count; it is always ready and meant to be written only
// while the block is idle.
// one read/write memory of 2*MAX_ENTRIES nodes holds {max, sum} per node, and
// a small sequencer walks the tree node by node through its single
// read port, sharing one adder and one signed compare.
// the steps of each command:
//   update: descent to the leaf, leaf write, then a read and a write per level
//   query : one node per cycle down to a covered node or the split, then the left
//           and right walks, then a drain of the registered read; a flagged query only drains
// the block accepts no new transaction while one is being worked on.
// after reset a clearing pass zeroes all 2*MAX_ENTRIES nodes with s_tready
// low; element_count resets to 32768.
// a finished result waits in the output register; a stalled receiver only
// holds off the next query at its final step, updates keep going.
`default_nettype none

module range_sum_max_segment_tree
    import rsmst_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // first_index[15:0], last_index[31:16], new_value[47:32]
    input  wire logic [1:0]  s_tuser,   // cmd[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // answer[31:0]
    output logic             m_tuser,   // bad_request[0]
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [15:0] cfg_data
);

    localparam int NODE_SLOTS = 2 * MAX_ENTRIES;
    localparam int ADDR_W     = $clog2(NODE_SLOTS);
    localparam int NODE_W     = $clog2(MAX_ENTRIES) + 2;
    localparam int IDX_W      = ($clog2(MAX_ENTRIES + 1) > 16) ? $clog2(MAX_ENTRIES + 1) : 16;
    localparam int RAM_W      = SUM_W + VAL_W;

    localparam logic [NODE_W-1:0] SLOT_LIMIT = NODE_W'(NODE_SLOTS);
    localparam logic [NODE_W-1:0] ROOT       = NODE_W'(1);
    localparam logic [IDX_W-1:0]  N_MAX      = IDX_W'(MAX_ENTRIES);
    localparam logic [IDX_W-1:0]  IDX_ONE    = IDX_W'(1);
    localparam logic [ADDR_W-1:0] LAST_ADDR  = ADDR_W'(NODE_SLOTS - 1);
    localparam logic [ADDR_W-1:0] ADDR_ONE   = ADDR_W'(1);
    localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

    function automatic logic in_slots(input logic [NODE_W-1:0] node);
        return node < SLOT_LIMIT;
    endfunction

    // control and walker registers
    state_t                    state_reg, state_next;
    logic [ADDR_W-1:0]         clr_reg, clr_next;
    logic [15:0]               count_reg;
    cmd_t                      cmd_reg, cmd_next;
    logic [IDX_W-1:0]          lo_reg, lo_next, hi_reg, hi_next;
    logic [NODE_W-1:0]         k_reg, k_next;
    logic [IDX_W-1:0]          slo_reg, slo_next, shi_reg, shi_next;
    logic [NODE_W-1:0]         sk_reg, sk_next;
    logic [IDX_W-1:0]          a_reg, a_next, b_reg, b_next;
    logic signed [VAL_W-1:0]   val_reg, val_next;
    logic [SUM_W-1:0]          cur_sum_reg, cur_sum_next;
    logic signed [VAL_W-1:0]   cur_max_reg, cur_max_next;
    logic [SUM_W-1:0]          acc_sum_reg, acc_sum_next;
    logic signed [VAL_W-1:0]   acc_max_reg, acc_max_next;
    logic                      pend_reg, pend_next;
    logic                      pend_in_reg, pend_in_next;
    logic                      bad_reg, bad_next;
    logic                      out_valid_reg, out_valid_next;
    logic [31:0]               out_data_reg, out_data_next;
    logic                      out_bad_reg, out_bad_next;

    // memory port
    logic                      ram_we;
    logic [NODE_W-1:0]         wr_node;
    logic [ADDR_W-1:0]         ram_waddr;
    logic [RAM_W-1:0]          ram_wdata;
    logic [NODE_W-1:0]         rd_node;
    logic [RAM_W-1:0]          ram_rdata;

    // shared datapath
    logic [IDX_W-1:0]          n_eff, count_ext;
    logic [IDX_W:0]            mid_sum;
    logic [IDX_W-1:0]          mid, mid_p1;
    logic [NODE_W-1:0]         child_l, child_r, parent;
    logic [SUM_W-1:0]          rd_sum;
    logic signed [VAL_W-1:0]   rd_max;
    logic [SUM_W-1:0]          add_res;
    logic signed [VAL_W-1:0]   max_res;
    logic [SUM_W-1:0]          add_a;
    logic signed [VAL_W-1:0]   max_a;

    logic                      in_acc;
    logic [IDX_W-1:0]          in_first, in_last;
    logic                      q_bad, upd_ok;

    assign count_ext = IDX_W'(count_reg);
    assign n_eff     = (count_ext > N_MAX) ? N_MAX : count_ext;
    assign mid_sum   = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid       = mid_sum[IDX_W:1];
    assign mid_p1    = mid + IDX_ONE;
    assign child_l   = {k_reg[NODE_W-2:0], 1'b0};
    assign child_r   = {k_reg[NODE_W-2:0], 1'b1};
    assign parent    = {1'b0, k_reg[NODE_W-1:1]};

    // nodes beyond the store read as zero
    assign rd_sum = pend_in_reg ? ram_rdata[SUM_W-1:0] : '0;
    assign rd_max = pend_in_reg ? signed'(ram_rdata[RAM_W-1:SUM_W]) : '0;

    // one adder and one signed compare, shared by the ascent and the query
    always_comb
    begin
        if ((state_reg == ST_UP_WRITE) || (state_reg == ST_UPD_DOWN))
        begin
            add_a = cur_sum_reg;
            max_a = cur_max_reg;
        end
        else
        begin
            add_a = acc_sum_reg;
            max_a = acc_max_reg;
        end
    end
    assign add_res = add_a + rd_sum;
    assign max_res = (rd_max > max_a) ? rd_max : max_a;

    assign in_acc   = s_tvalid && s_tready;
    assign in_first = IDX_W'(s_tdata[15:0]);
    assign in_last  = IDX_W'(s_tdata[31:16]);
    assign q_bad    = (in_first < IDX_ONE) || (in_first > in_last) || (in_last > n_eff);
    assign upd_ok   = (in_first >= IDX_ONE) && (in_first <= n_eff);

    rsmst_ram #(
        .WIDTH (RAM_W),
        .DEPTH (NODE_SLOTS)
    ) u_nodes (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (rd_node[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_reg == LAST_ADDR)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    unique case (cmd_t'(s_tuser))
                        CMD_UPDATE: state_next = upd_ok ? ST_UPD_DOWN : ST_IDLE;
                        CMD_MAX, CMD_SUM: state_next = q_bad ? ST_Q_DRAIN : ST_Q_SPLIT;
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_UPD_DOWN:
            begin
                if (lo_reg == hi_reg)
                begin
                    state_next = (k_reg == ROOT) ? ST_IDLE : ST_UP_READ;
                end
            end
            ST_UP_READ:
            begin
                state_next = ST_UP_WRITE;
            end
            ST_UP_WRITE:
            begin
                state_next = (parent == ROOT) ? ST_IDLE : ST_UP_READ;
            end
            ST_Q_SPLIT:
            begin
                if ((a_reg <= lo_reg) && (hi_reg <= b_reg))
                begin
                    state_next = ST_Q_DRAIN;
                end
                else if ((b_reg > mid) && (a_reg <= mid))
                begin
                    state_next = ST_Q_LEFT;
                end
            end
            ST_Q_LEFT:
            begin
                if (a_reg <= lo_reg)
                begin
                    state_next = ST_Q_RIGHT;
                end
            end
            ST_Q_RIGHT:
            begin
                if (hi_reg <= b_reg)
                begin
                    state_next = ST_Q_DRAIN;
                end
            end
            ST_Q_DRAIN:
            begin
                if (!pend_reg && (!out_valid_reg || m_tready))
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        clr_next     = clr_reg;
        cmd_next     = cmd_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        k_next       = k_reg;
        slo_next     = slo_reg;
        shi_next     = shi_reg;
        sk_next      = sk_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        val_next     = val_reg;
        cur_sum_next = cur_sum_reg;
        cur_max_next = cur_max_reg;
        acc_sum_next = acc_sum_reg;
        acc_max_next = acc_max_reg;
        pend_next    = 1'b0;
        pend_in_next = 1'b0;
        bad_next     = bad_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        out_bad_next   = out_bad_reg;
        ram_we       = 1'b0;
        wr_node      = k_reg;
        ram_wdata    = '0;
        rd_node      = k_reg;

        // a read issued last cycle lands in the query accumulator
        if (pend_reg && (state_reg != ST_UP_WRITE))
        begin
            acc_sum_next = add_res;
            acc_max_next = max_res;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we   = 1'b1;
                wr_node  = NODE_W'(clr_reg);
                clr_next = clr_reg + ADDR_ONE;
            end
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    cmd_next     = cmd_t'(s_tuser);
                    lo_next      = IDX_ONE;
                    hi_next      = n_eff;
                    k_next       = ROOT;
                    a_next       = in_first;
                    b_next       = in_last;
                    val_next     = signed'(s_tdata[47:32]);
                    acc_sum_next = '0;
                    acc_max_next = VAL_MIN;
                    bad_next     = q_bad;
                end
            end
            ST_UPD_DOWN:
            begin
                if (lo_reg == hi_reg)
                begin
                    ram_we       = in_slots(k_reg);
                    ram_wdata    = {val_reg, SUM_W'(val_reg)};
                    cur_sum_next = in_slots(k_reg) ? SUM_W'(val_reg) : '0;
                    cur_max_next = in_slots(k_reg) ? val_reg : '0;
                end
                else if (a_reg <= mid)
                begin
                    hi_next = mid;
                    k_next  = child_l;
                end
                else
                begin
                    lo_next = mid_p1;
                    k_next  = child_r;
                end
            end
            ST_UP_READ:
            begin
                rd_node      = {k_reg[NODE_W-1:1], ~k_reg[0]};
                pend_in_next = in_slots({k_reg[NODE_W-1:1], ~k_reg[0]});
            end
            ST_UP_WRITE:
            begin
                wr_node      = parent;
                ram_we       = in_slots(parent);
                ram_wdata    = {max_res, add_res};
                cur_sum_next = in_slots(parent) ? add_res : '0;
                cur_max_next = in_slots(parent) ? max_res : '0;
                k_next       = parent;
            end
            ST_Q_SPLIT:
            begin
                if ((a_reg <= lo_reg) && (hi_reg <= b_reg))
                begin
                    pend_next    = 1'b1;
                    pend_in_next = in_slots(k_reg);
                end
                else if (b_reg <= mid)
                begin
                    hi_next = mid;
                    k_next  = child_l;
                end
                else if (a_reg > mid)
                begin
                    lo_next = mid_p1;
                    k_next  = child_r;
                end
                else
                begin
                    // range splits here: park the right half, walk the left
                    slo_next = mid_p1;
                    shi_next = hi_reg;
                    sk_next  = child_r;
                    hi_next  = mid;
                    k_next   = child_l;
                end
            end
            ST_Q_LEFT:
            begin
                if (a_reg <= lo_reg)
                begin
                    pend_next    = 1'b1;
                    pend_in_next = in_slots(k_reg);
                    lo_next      = slo_reg;
                    hi_next      = shi_reg;
                    k_next       = sk_reg;
                end
                else if (a_reg <= mid)
                begin
                    rd_node      = child_r;
                    pend_next    = 1'b1;
                    pend_in_next = in_slots(child_r);
                    hi_next      = mid;
                    k_next       = child_l;
                end
                else
                begin
                    lo_next = mid_p1;
                    k_next  = child_r;
                end
            end
            ST_Q_RIGHT:
            begin
                if (hi_reg <= b_reg)
                begin
                    pend_next    = 1'b1;
                    pend_in_next = in_slots(k_reg);
                end
                else if (b_reg > mid)
                begin
                    rd_node      = child_l;
                    pend_next    = 1'b1;
                    pend_in_next = in_slots(child_l);
                    lo_next      = mid_p1;
                    k_next       = child_r;
                end
                else
                begin
                    hi_next = mid;
                    k_next  = child_l;
                end
            end
            ST_Q_DRAIN:
            begin
                if (!pend_reg && (!out_valid_reg || m_tready))
                begin
                    out_valid_next = 1'b1;
                    out_bad_next   = bad_reg;
                    if (bad_reg)
                    begin
                        out_data_next = '0;
                    end
                    else if (cmd_reg == CMD_MAX)
                    begin
                        out_data_next = 32'(acc_max_reg);
                    end
                    else
                    begin
                        out_data_next = acc_sum_reg;
                    end
                end
            end
            default:
            begin
                clr_next = clr_reg;
            end
        endcase
    end

    assign ram_waddr = wr_node[ADDR_W-1:0];

    // outputs
    always_comb
    begin
        s_tready  = (state_reg == ST_IDLE);
        m_tvalid  = out_valid_reg;
        m_tdata   = out_data_reg;
        m_tuser   = out_bad_reg;
        cfg_ready = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            count_reg     <= COUNT_RESET;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                count_reg <= cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        k_reg        <= k_next;
        slo_reg      <= slo_next;
        shi_reg      <= shi_next;
        sk_reg       <= sk_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        val_reg      <= val_next;
        cur_sum_reg  <= cur_sum_next;
        cur_max_reg  <= cur_max_next;
        acc_sum_reg  <= acc_sum_next;
        acc_max_reg  <= acc_max_next;
        pend_in_reg  <= pend_in_next;
        bad_reg      <= bad_next;
        out_data_reg <= out_data_next;
        out_bad_reg  <= out_bad_next;
    end

endmodule

`default_nettype wire

@@ hdl/rsmst_checker.sv @@
// port-level checker for the segment tree, bound to the top level
`default_nettype none

module rsmst_checker
    import rsmst_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [1:0]  s_tuser,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata,
    input wire logic        m_tuser
);

    // a held result stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // a held result keeps its value
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // flagged results carry a zero answer
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata == 32'd0)
        else $error("flagged result with nonzero answer");

    // a query keeps the block busy on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == CMD_MAX || s_tuser == CMD_SUM) |=> !s_tready)
        else $error("ready right after a query");

endmodule

bind range_sum_max_segment_tree rsmst_checker u_rsmst_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

@@ bench/tb_range_sum_max_segment_tree.sv @@
// self-checking testbench for the range sum / max segment tree
`timescale 1ns / 100ps
`default_nettype none

module tb_range_sum_max_segment_tree;
    import rsmst_pkg::*;

    localparam int NODES = 2 * MAX_ENTRIES_DEF;
    localparam int LIMIT = 3000000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic [1:0]  s_tuser = CMD_NONE;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data = '0;

    always #5 clk = ~clk;

    range_sum_max_segment_tree dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    // model copy of the node store and register
    logic [31:0]        sum_tree [NODES];
    logic signed [15:0] max_tree [NODES];
    logic [15:0]        count_reg;

    typedef struct packed {
        logic [31:0] answer;
        logic        bad;
    } answer_t;

    answer_t pending_answers[$];
    int      errors = 0;
    int      cycles = 0;
    bit      calm = 1'b0;

    function automatic int active_count();
        return (count_reg > MAX_ENTRIES_DEF) ? MAX_ENTRIES_DEF : int'(count_reg);
    endfunction

    function automatic void tree_write(int pos, logic signed [15:0] val, int lo, int hi, int k);
        int mid;
        logic signed [15:0] a, b;
        if (lo == hi) begin
            if (k < NODES) begin
                sum_tree[k] = {{16{val[15]}}, val};
                max_tree[k] = val;
            end
            return;
        end
        mid = (lo + hi) >> 1;
        if (pos <= mid) tree_write(pos, val, lo, mid, 2 * k);
        else            tree_write(pos, val, mid + 1, hi, 2 * k + 1);
        if (k < NODES) begin
            a = (2 * k < NODES) ? max_tree[2 * k] : 16'sd0;
            b = (2 * k + 1 < NODES) ? max_tree[2 * k + 1] : 16'sd0;
            sum_tree[k] = ((2 * k < NODES) ? sum_tree[2 * k] : 32'd0)
                        + ((2 * k + 1 < NODES) ? sum_tree[2 * k + 1] : 32'd0);
            max_tree[k] = (a > b) ? a : b;
        end
    endfunction

    function automatic logic signed [15:0] tree_max(int a, int b, int lo, int hi, int k);
        int mid;
        logic signed [15:0] best, t;
        bit seen;
        best = -16'sd32768;
        seen = 1'b0;
        if (a <= lo && hi <= b) return (k < NODES) ? max_tree[k] : 16'sd0;
        mid = (lo + hi) >> 1;
        if (a <= mid) begin
            best = tree_max(a, b, lo, mid, 2 * k);
            seen = 1'b1;
        end
        if (b > mid) begin
            t = tree_max(a, b, mid + 1, hi, 2 * k + 1);
            if (!seen || t > best) best = t;
        end
        return best;
    endfunction

    function automatic logic [31:0] tree_sum(int a, int b, int lo, int hi, int k);
        int mid;
        logic [31:0] acc;
        acc = '0;
        if (a <= lo && hi <= b) return (k < NODES) ? sum_tree[k] : 32'd0;
        mid = (lo + hi) >> 1;
        if (a <= mid) acc += tree_sum(a, b, lo, mid, 2 * k);
        if (b > mid)  acc += tree_sum(a, b, mid + 1, hi, 2 * k + 1);
        return acc;
    endfunction

    // apply one accepted transaction to the model, queue its answer if any
    function automatic void predict_answer(cmd_t cmd, int first, int last,
                                           logic signed [15:0] val);
        int n;
        answer_t r;
        logic signed [15:0] m;
        n = active_count();
        if (cmd == CMD_UPDATE) begin
            if (first >= 1 && first <= n) tree_write(first, val, 1, n, 1);
            return;
        end
        if (cmd == CMD_NONE) return;
        if (first < 1 || first > last || last > n) begin
            r.answer = '0;
            r.bad = 1'b1;
        end else if (cmd == CMD_MAX) begin
            m = tree_max(first, last, 1, n, 1);
            r.answer = {{16{m[15]}}, m};
            r.bad = 1'b0;
        end else begin
            r.answer = tree_sum(first, last, 1, n, 1);
            r.bad = 1'b0;
        end
        pending_answers = {pending_answers, r};
    endfunction

    // watchdog
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("%0t timeout", $time);
            $display("range_sum_max_segment_tree verification failed");
            $finish;
        end
    end

    // result checker, samples at the rising edge
    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready) begin
            if (pending_answers.size() == 0) begin
                errors <= errors + 1;
                $display("%0t unexpected result answer=%h bad=%b", $time, m_tdata, m_tuser);
            end else begin
                if (m_tdata !== pending_answers[0].answer ||
                    m_tuser !== pending_answers[0].bad) begin
                    errors <= errors + 1;
                    $display("%0t mismatch expected answer=%h bad=%b actual answer=%h bad=%b",
                             $time, pending_answers[0].answer, pending_answers[0].bad,
                             m_tdata, m_tuser);
                end
                void'(pending_answers.pop_front());
            end
        end
    end

    // receiver stalls in bursts, none in the calm tail
    initial begin
        int gap;
        forever begin
            @(negedge clk);
            if (!calm && $urandom_range(0, 3) == 0) begin
                gap = $urandom_range(1, 5);
                m_tready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_tready <= 1'b1;
        end
    end

    // one input transaction, with an optional idle burst ahead of it
    task automatic send_item(cmd_t cmd, logic [15:0] first, logic [15:0] last,
                             logic [15:0] val);
        int gap;
        if (!calm && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 5);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {val, last, first};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        predict_answer(cmd, first, last, val);
        @(negedge clk);
    endtask

    task automatic drain_answers();
        s_tvalid <= 1'b0;
        while (pending_answers.size() != 0) @(negedge clk);
        repeat (200) @(negedge clk);
    endtask

    task automatic write_count(logic [15:0] value);
        drain_answers();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        count_reg = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // random transaction biased toward valid indices and small ranges
    task automatic random_item(int n);
        int sel, f, l;
        cmd_t cmd;
        sel = $urandom_range(0, 99);
        cmd = (sel < 45) ? CMD_UPDATE : (sel < 70) ? CMD_MAX : (sel < 96) ? CMD_SUM : CMD_NONE;
        if ($urandom_range(0, 9) == 0) begin
            f = $urandom_range(0, 65535);
            l = $urandom_range(0, 65535);
        end else begin
            f = (n > 0) ? $urandom_range(1, n) : 1;
            l = ($urandom_range(0, 3) == 0) ? $urandom_range(f, (n > f) ? n : f)
                                            : ((f + $urandom_range(0, 8) > n) ? n
                                               : f + $urandom_range(0, 8));
            if ($urandom_range(0, 15) == 0) l = f - 1;
        end
        send_item(cmd, f[15:0], l[15:0], 16'($urandom_range(0, 65535)));
    endtask

    typedef struct {
        cmd_t        cmd;
        logic [15:0] first;
        logic [15:0] last;
        logic [15:0] val;
        bit          typed;     // answer typed in below
        logic [31:0] answer;
        logic        bad;
    } step_t;

    step_t plan[] = '{
        // empty tree after reset
        '{CMD_SUM,    16'd1,     16'd32768, 16'h0000, 1, 32'd0, 1'b0},
        '{CMD_MAX,    16'd1,     16'd32768, 16'h0000, 1, 32'd0, 1'b0},
        // error cases
        '{CMD_SUM,    16'd0,     16'd5,     16'h0000, 1, 32'd0, 1'b1},
        '{CMD_MAX,    16'd9,     16'd8,     16'h0000, 1, 32'd0, 1'b1},
        '{CMD_SUM,    16'd1,     16'd32769, 16'h0000, 1, 32'd0, 1'b1},
        '{CMD_MAX,    16'hffff,  16'hffff,  16'h0000, 1, 32'd0, 1'b1},
        // extremes of value and index
        '{CMD_UPDATE, 16'd1,     16'd0,     16'h7fff, 0, 32'd0, 1'b0},
        '{CMD_UPDATE, 16'd32768, 16'hffff,  16'h8000, 0, 32'd0, 1'b0},
        '{CMD_UPDATE, 16'd0,     16'd0,     16'h1234, 0, 32'd0, 1'b0},
        '{CMD_UPDATE, 16'd32769, 16'd0,     16'h1234, 0, 32'd0, 1'b0},
        '{CMD_NONE,   16'd1,     16'd1,     16'hffff, 0, 32'd0, 1'b0},
        '{CMD_MAX,    16'd1,     16'd1,     16'h0000, 1, 32'h00007fff, 1'b0},
        '{CMD_MAX,    16'd32768, 16'd32768, 16'h0000, 1, 32'hffff8000, 1'b0},
        '{CMD_SUM,    16'd1,     16'd32768, 16'h0000, 1, 32'hffffffff, 1'b0},
        '{CMD_MAX,    16'd2,     16'd32767, 16'h0000, 0, 32'd0, 1'b0},
        '{CMD_UPDATE, 16'd16384, 16'd0,     16'hffff, 0, 32'd0, 1'b0},
        '{CMD_SUM,    16'd16384, 16'd16385, 16'h0000, 0, 32'd0, 1'b0},
        '{CMD_MAX,    16'd16000, 16'd32768, 16'h0000, 0, 32'd0, 1'b0}
    };

    initial begin
        int n, phase;
        count_reg = COUNT_RESET;
        for (int k = 0; k < NODES; k++) begin
            sum_tree[k] = '0;
            max_tree[k] = '0;
        end
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        // directed table
        foreach (plan[i]) begin
            if (plan[i].typed) begin
                answer_t r;
                drain_answers();
                send_item(plan[i].cmd, plan[i].first, plan[i].last, plan[i].val);
                r = pending_answers[$];
                if (r.answer !== plan[i].answer || r.bad !== plan[i].bad) begin
                    errors++;
                    $display("%0t table row %0d expected answer=%h bad=%b model=%h bad=%b",
                             $time, i, plan[i].answer, plan[i].bad, r.answer, r.bad);
                end
            end else begin
                send_item(plan[i].cmd, plan[i].first, plan[i].last, plan[i].val);
            end
        end

        // register extremes: zero flags everything, above max saturates
        write_count(16'd0);
        send_item(CMD_SUM, 16'd1, 16'd1, 16'h0);
        send_item(CMD_UPDATE, 16'd1, 16'd0, 16'h5555);
        write_count(16'hffff);
        send_item(CMD_SUM, 16'd1, 16'd32768, 16'h0);
        write_count(16'd1);
        send_item(CMD_UPDATE, 16'd1, 16'd0, 16'haaaa);
        send_item(CMD_MAX, 16'd1, 16'd1, 16'h0);

        // random phases over several sizes, small ones mostly
        for (phase = 0; phase < 8; phase++) begin
            case (phase)
                0: n = 1;
                1: n = 2;
                2: n = $urandom_range(3, 16);
                3: n = $urandom_range(17, 200);
                4: n = 32768;
                5: n = $urandom_range(3, 64);
                6: n = $urandom_range(1000, 32767);
                default: n = $urandom_range(2, 32);
            endcase
            write_count(n[15:0]);
            if (phase == 7) calm = 1'b1;
            repeat (230) random_item(n);
        end

        drain_answers();
        if (errors == 0)
            $display("range_sum_max_segment_tree verification clean");
        else
            $display("range_sum_max_segment_tree verification failed");
        $finish;
    end

endmodule

`default_nettype wire

@@ range_sum_max_segment_tree.f @@
hdl/rsmst_pkg.sv
hdl/rsmst_ram.sv
hdl/range_sum_max_segment_tree.sv
hdl/rsmst_checker.sv
bench/tb_range_sum_max_segment_tree.sv
